/* hw/rtl/mf24_pkg.sv */
// types and constants shared by the 24-bit minifloat arithmetic unit
// no dependencies
package mf24_pkg;

    typedef enum logic [2:0] {
        CMD_ADD  = 3'd0,
        CMD_SUB  = 3'd1,
        CMD_MUL  = 3'd2,
        CMD_FROM = 3'd3,
        CMD_TO   = 3'd4
    } cmd_t;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_OVF   = 2'd1;
    localparam logic [1:0] ST_UNF   = 2'd2;
    localparam logic [23:0] PINF    = 24'h7E0000;

    typedef struct packed {
        logic [2:0]  command;
        logic [31:0] operand_a;
        logic [23:0] operand_b;
    } in_word_t;

    typedef struct packed {
        logic [31:0] result_word;
        logic [1:0]  status;
    } out_word_t;

    // sign, signed exponent, 19-bit significand between stages
    typedef struct packed {
        logic        vld;
        logic [2:0]  cmd;
        logic        done;
        logic [31:0] word;
        logic [1:0]  st;
        logic        sign;
        logic [9:0]  exp;
        logic [18:0] ma;
        logic [18:0] mb;
        logic        sub;
    } stage_t;

    function automatic logic [31:0] pack24(input logic s, input logic [9:0] e,
                                           input logic [18:0] m,
                                           output logic [1:0] st);
        logic signed [10:0] be;
        be = $signed({e[9], e}) + 11'sd31;
        if (be > 11'sd62) begin
            st = ST_OVF;
            return {8'd0, PINF};
        end
        if (be < 11'sd0) begin
            st = ST_UNF;
            return 32'd0;
        end
        st = ST_OK;
        return {8'd0, s, be[5:0], m[16:0]};
    endfunction

endpackage

/* hw/rtl/minifloat24_add_mul_convert.sv */
// top level of the 24-bit minifloat add, multiply and convert unit
// depends on mf24_pkg, mf24_front, mf24_core, mf24_norm
//
// one word is taken every cycle (busy stays low); its result shows on
// result with done high after the three register stages: decode and
// align, add or multiply, normalize and pack; the receiver cannot stall,
// so nothing ever holds the pipeline
module minifloat24_add_mul_convert (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  mf24_pkg::in_word_t  operands,
    output logic                done,
    output mf24_pkg::out_word_t result
);
    import mf24_pkg::*;

    stage_t s1, s2;

    mf24_front u_front (
        .clk     (clk),
        .rst_n   (rst_n),
        .in_vld  (start && !busy),
        .in_word (operands),
        .s1      (s1)
    );

    mf24_core u_core (
        .clk   (clk),
        .rst_n (rst_n),
        .s1    (s1),
        .s2    (s2)
    );

    mf24_norm u_norm (
        .clk      (clk),
        .rst_n    (rst_n),
        .s2       (s2),
        .out_vld  (done),
        .out_word (result)
    );

    assign busy = 1'b0;
endmodule

/* hw/rtl/mf24_front.sv */
// stage 1: decode, align for add, multiply exponent and sign, conversions
// depends on mf24_pkg
module mf24_front (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_vld,
    input  mf24_pkg::in_word_t in_word,
    output mf24_pkg::stage_t   s1
);
    import mf24_pkg::*;

    stage_t s1_reg, s1_next;
    logic [23:0] a, b;
    logic [9:0]  ea, eb, d;
    logic [18:0] ma, mb;
    logic [1:0]  st;
    logic [31:0] w;
    logic [7:0]  e8;

    always_comb
    begin
        s1_next = '0;
        s1_next.vld = in_vld;
        s1_next.cmd = in_word.command;
        a = in_word.operand_a[23:0];
        b = in_word.operand_b;
        if (in_word.command == CMD_SUB && b != 24'd0)
        begin
            b[23] = ~b[23];
        end
        ea = 10'(a[22:17]) - 10'd31;
        eb = 10'(b[22:17]) - 10'd31;
        ma = {2'b01, a[16:0]};
        mb = {2'b01, b[16:0]};
        d = '0;
        st = ST_OK;
        w = '0;
        e8 = in_word.operand_a[30:23];
        case (in_word.command)
            CMD_ADD, CMD_SUB:
            begin
                if (a == 24'd0)
                begin
                    s1_next.done = 1'b1;
                    s1_next.word = {8'd0, b};
                end
                else if (b == 24'd0)
                begin
                    s1_next.done = 1'b1;
                    s1_next.word = {8'd0, a};
                end
                else if ($signed(ea) > $signed(eb))
                begin
                    d = ea - eb;
                    s1_next.exp = ea;
                    s1_next.ma = ma;
                    s1_next.mb = (d > 10'd31) ? 19'd0 : (mb >> d[4:0]);
                end
                else
                begin
                    d = eb - ea;
                    s1_next.exp = eb;
                    s1_next.mb = mb;
                    s1_next.ma = (d > 10'd31) ? 19'd0 : (ma >> d[4:0]);
                end
                s1_next.sign = a[23];
                s1_next.sub = a[23] ^ b[23];
                if (s1_next.sub && s1_next.mb > s1_next.ma)
                begin
                    s1_next.sign = b[23];
                end
            end
            CMD_MUL:
            begin
                if (a == 24'd0 || b == 24'd0)
                begin
                    s1_next.done = 1'b1;
                end
                else
                begin
                    s1_next.exp = ea + eb;
                    s1_next.sign = a[23] ^ b[23];
                    s1_next.ma = ma;
                    s1_next.mb = mb;
                end
            end
            CMD_FROM:
            begin
                s1_next.done = 1'b1;
                if (in_word.operand_a[30:0] == 31'd0)
                begin
                    s1_next.word = '0;
                end
                else if (e8 == 8'd0)
                begin
                    s1_next.st = ST_UNF;
                end
                else
                begin
                    s1_next.word = pack24(in_word.operand_a[31],
                        10'(e8) - 10'd127,
                        {2'b01, in_word.operand_a[22:6]}, st);
                    s1_next.st = st;
                end
            end
            CMD_TO:
            begin
                s1_next.done = 1'b1;
                if (a != 24'd0)
                begin
                    w = {a[23], 8'(a[22:17]) + 8'd96, a[16:0], 6'd0};
                end
                s1_next.word = w;
            end
            default:
            begin
                s1_next.done = 1'b1;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg <= '0;
        end
        else
        begin
            s1_reg <= s1_next;
        end
    end

    assign s1 = s1_reg;
endmodule

/* hw/rtl/mf24_core.sv */
// stage 2: significand add or subtract, 18x18 multiply
// depends on mf24_pkg
module mf24_core (
    input  logic             clk,
    input  logic             rst_n,
    input  mf24_pkg::stage_t s1,
    output mf24_pkg::stage_t s2
);
    import mf24_pkg::*;

    stage_t s2_reg, s2_next;
    logic [35:0] prod;

    always_comb
    begin
        s2_next = s1;
        prod = 36'(s1.ma[17:0]) * 36'(s1.mb[17:0]);
        if (!s1.done)
        begin
            if (s1.cmd == CMD_MUL)
            begin
                s2_next.ma = prod[35:17];
            end
            else if (s1.sub)
            begin
                if (s1.ma == s1.mb)
                begin
                    s2_next.done = 1'b1;
                    s2_next.word = '0;
                    s2_next.st = ST_OK;
                end
                s2_next.ma = (s1.ma > s1.mb) ? s1.ma - s1.mb : s1.mb - s1.ma;
            end
            else
            begin
                s2_next.ma = s1.ma + s1.mb;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s2_reg <= '0;
        end
        else
        begin
            s2_reg <= s2_next;
        end
    end

    assign s2 = s2_reg;
endmodule

/* hw/rtl/mf24_norm.sv */
// stage 3: leading-zero normalize, exponent range check and pack
// depends on mf24_pkg
module mf24_norm (
    input  logic                clk,
    input  logic                rst_n,
    input  mf24_pkg::stage_t    s2,
    output logic                out_vld,
    output mf24_pkg::out_word_t out_word
);
    import mf24_pkg::*;

    logic      vld_reg;
    out_word_t out_reg, out_next;
    logic [18:0] m;
    logic [9:0]  e;
    logic [4:0]  lz;
    logic [1:0]  st;

    always_comb
    begin
        m = s2.ma;
        e = s2.exp;
        lz = 5'd0;
        if (m[18])
        begin
            m = m >> 1;
            e = e + 10'd1;
        end
        else if (!m[17])
        begin
            for (int i = 16; i >= 0; i--)
            begin
                if (m[i] && lz == 5'd0)
                begin
                    lz = 5'(17 - i);
                end
            end
            m = m << lz;
            e = e - 10'(lz);
        end
        out_next.result_word = pack24(s2.sign, e, m, st);
        out_next.status = st;
        if (s2.done)
        begin
            out_next.result_word = s2.word;
            out_next.status = s2.st;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= 1'b0;
        end
        else
        begin
            vld_reg <= s2.vld;
        end
    end

    always_ff @(posedge clk)
    begin
        out_reg <= out_next;
    end

    assign out_vld = vld_reg;
    assign out_word = out_reg;
endmodule

/* tb/sv/mf24_checker.sv */
`timescale 1ns / 1ps
// checker for the minifloat24 unit: watches accepted words and results,
// predicts each result and compares field by field; depends on mf24_pkg
module mf24_checker (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic                busy,
    input  mf24_pkg::in_word_t  operands,
    input  logic                done,
    input  mf24_pkg::out_word_t result,
    output int                  errors,
    output int                  pending
);
    import mf24_pkg::*;

    out_word_t expected_q[$];

    function automatic out_word_t pack_f24(logic s, int e, logic [31:0] m);
        out_word_t r;
        int be;
        be = e + 31;
        if (be > 62) begin
            r.result_word = {8'd0, PINF};
            r.status = ST_OVF;
        end else if (be < 0) begin
            r.result_word = '0;
            r.status = ST_UNF;
        end else begin
            r.result_word = {8'd0, s, be[5:0], m[16:0]};
            r.status = ST_OK;
        end
        return r;
    endfunction

    function automatic out_word_t sum_f24(logic [23:0] a, logic [23:0] b);
        out_word_t r;
        logic [31:0] ma, mb, rm;
        logic rs;
        int ea, eb, re, d;
        if (a == 0) return '{{8'd0, b}, ST_OK};
        if (b == 0) return '{{8'd0, a}, ST_OK};
        ea = int'(a[22:17]) - 31;
        eb = int'(b[22:17]) - 31;
        ma = {14'd0, 1'b1, a[16:0]};
        mb = {14'd0, 1'b1, b[16:0]};
        if (ea > eb) begin
            d = ea - eb;
            mb = (d > 31) ? 0 : mb >> d;
            re = ea;
        end else begin
            d = eb - ea;
            ma = (d > 31) ? 0 : ma >> d;
            re = eb;
        end
        if (a[23] != b[23]) begin
            if (ma == mb) return '{32'd0, ST_OK};
            if (ma > mb) begin
                rm = ma - mb;
                rs = a[23];
            end else begin
                rm = mb - ma;
                rs = b[23];
            end
            while (rm < 32'h20000) begin
                rm = rm << 1;
                re--;
            end
        end else begin
            rs = a[23];
            rm = ma + mb;
            if (rm[18]) begin
                rm = rm >> 1;
                re++;
            end
        end
        return pack_f24(rs, re, rm);
    endfunction

    function automatic out_word_t product_f24(logic [23:0] a, logic [23:0] b);
        logic [63:0] p;
        int re;
        if (a == 0 || b == 0) return '{32'd0, ST_OK};
        re = int'(a[22:17]) + int'(b[22:17]) - 62;
        p = {46'd0, 1'b1, a[16:0]} * {46'd0, 1'b1, b[16:0]};
        p = p >> 17;
        if (p[18]) begin
            p = p >> 1;
            re++;
        end
        return pack_f24(a[23] ^ b[23], re, p[31:0]);
    endfunction

    function automatic out_word_t predict_result(in_word_t w);
        logic [23:0] a, b;
        logic [31:0] f;
        a = w.operand_a[23:0];
        b = w.operand_b;
        f = w.operand_a;
        case (w.command)
            CMD_ADD: return sum_f24(a, b);
            CMD_SUB: return sum_f24(a, (b == 0) ? b : {~b[23], b[22:0]});
            CMD_MUL: return product_f24(a, b);
            CMD_FROM:
            begin
                if (f[30:0] == 0) return '{32'd0, ST_OK};
                if (f[30:23] == 0) return '{32'd0, ST_UNF};
                return pack_f24(f[31], int'(f[30:23]) - 127, {15'd0, f[22:6]});
            end
            CMD_TO:
            begin
                if (a == 0) return '{32'd0, ST_OK};
                return '{{a[23], 8'(int'(a[22:17]) + 96), a[16:0], 6'd0}, ST_OK};
            end
            default: return '{32'd0, ST_OK};
        endcase
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        out_word_t e;
        if (!rst_n) begin
            errors <= 0;
        end else begin
            if (done) begin
                if (expected_q.size() == 0) begin
                    if (errors < 10)
                        $display("unexpected result %h/%0d", result.result_word,
                                 result.status);
                    errors <= errors + 1;
                end else begin
                    e = expected_q.pop_front();
                    if (e.result_word !== result.result_word ||
                        e.status !== result.status) begin
                        if (errors < 10)
                            $display("mismatch: expected %h/%0d got %h/%0d",
                                     e.result_word, e.status,
                                     result.result_word, result.status);
                        errors <= errors + 1;
                    end
                end
            end
            if (start && !busy)
                expected_q.push_back(predict_result(operands));
        end
    end

    assign pending = expected_q.size();

endmodule

/* tb/sv/tb_top.sv */
`timescale 1ns / 1ps
// testbench top for minifloat24_add_mul_convert: drives directed and random
// words in bursts; depends on mf24_pkg and mf24_checker
module tb_top;
    import mf24_pkg::*;

    logic      clk = 0;
    logic      rst_n = 0;
    logic      start = 0;
    logic      busy, done;
    in_word_t  operands = '0;
    out_word_t result;
    int        errors, pending;
    int        idle_cycles = 0;

    always #1 clk = ~clk;

    minifloat24_add_mul_convert dut (.clk, .rst_n, .start, .busy, .operands,
                                     .done, .result);
    mf24_checker chk (.clk, .rst_n, .start, .busy, .operands, .done, .result,
                      .errors, .pending);

    always @(posedge clk)
    begin
        if ((start && !busy) || done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > 2000) begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    function automatic logic [23:0] rand_f24();
        logic [23:0] v;
        v = 24'($urandom);
        case ($urandom_range(0, 9))
            0: v = 0;
            1: v[22:17] = $urandom_range(0, 1) ? 6'd63 : 6'd0;
            2: v[16:0] = $urandom_range(0, 1) ? 17'h1FFFF : 17'h0;
            default: ;
        endcase
        return v;
    endfunction

    function automatic logic [31:0] rand_f32();
        logic [31:0] v;
        v = $urandom;
        case ($urandom_range(0, 5))
            0: v[30:23] = 8'($urandom_range(96, 158));
            1: v[30:23] = $urandom_range(0, 1) ? 8'd0 : 8'hFF;
            2: v[30:0] = 0;
            default: ;
        endcase
        return v;
    endfunction

    task automatic send_word(logic [2:0] c, logic [31:0] a, logic [23:0] b);
        operands <= '{c, a, b};
        start <= 1;
        do @(posedge clk); while (busy);
        @(negedge clk);
    endtask

    task automatic maybe_gap();
        int g;
        if ($urandom_range(0, 7) == 0) begin
            start <= 0;
            g = $urandom_range(1, 6);
            repeat (g) @(negedge clk);
        end
    endtask

    initial
    begin
        logic [2:0] c;
        repeat (3) @(negedge clk);
        rst_n = 1;
        @(negedge clk);
        send_word(CMD_ADD, 0, 24'h3E0000);
        send_word(CMD_ADD, 32'h3E0000, 0);
        send_word(CMD_SUB, 32'h3E0000, 0);
        send_word(CMD_SUB, 32'h3E0000, 24'h3E0000);
        send_word(CMD_ADD, 32'h3E0000, 24'hBE0000);
        send_word(CMD_ADD, 32'h7FFFFF, 24'h7FFFFF);
        send_word(CMD_ADD, 32'h7E0000, 24'h000001);
        send_word(CMD_SUB, 32'h020001, 24'h020000);
        send_word(CMD_MUL, 32'h7FFFFF, 24'h7FFFFF);
        send_word(CMD_MUL, 32'h020000, 24'h820000);
        send_word(CMD_MUL, 0, 24'hFFFFFF);
        send_word(CMD_MUL, 32'hFF3FFFFF, 24'h3FFFFF);
        send_word(CMD_FROM, 32'h80000000, 0);
        send_word(CMD_FROM, 32'h00000001, 0);
        send_word(CMD_FROM, 32'h7F800000, 0);
        send_word(CMD_FROM, 32'h7FC00001, 0);
        send_word(CMD_FROM, 32'hBF80003F, 0);
        send_word(CMD_FROM, 32'h30000000, 0);
        send_word(CMD_TO, 32'hFF000000, 0);
        send_word(CMD_TO, 32'hFFFFFFFF, 0);
        send_word(CMD_TO, 32'h00000001, 0);
        send_word(3'd5, 32'hFFFFFFFF, 24'hFFFFFF);
        send_word(3'd7, 32'h1, 24'h1);
        for (int i = 0; i < 1850; i++) begin
            c = 3'($urandom_range(0, 7));
            if (c > 4 && $urandom_range(0, 3) != 0) c = 3'($urandom_range(0, 4));
            if (c == CMD_FROM)
                send_word(c, rand_f32(), 24'($urandom));
            else
                send_word(c, {8'($urandom), rand_f24()}, rand_f24());
            if (i > 400) maybe_gap();
        end
        start <= 0;
        while (pending != 0) @(negedge clk);
        repeat (10) @(negedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
